// ===== src/assert_macros.svh =====
// Assertion macros for the motor stall reverser RTL.
// Depends on signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, disabled while reset is asserted.
`define MSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define MSR_ASSERT_NEXT(lbl, pre, post, msg) \
	`MSR_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== src/msr_pkg.sv =====
// Shared types, widths and codes for the motor stall reverser.
// No dependencies; the interfaces, core, controller and datapath import this package.
`default_nettype none

package msr_pkg;

	// Sizing of the sample ring and derived widths.
	localparam int RING_DEPTH  = 8;
	localparam int SAMPLE_BITS = 12;
	localparam int SLOT_W      = $clog2(RING_DEPTH);
	localparam int FILL_W      = $clog2(RING_DEPTH + 1);
	localparam int SUM_W       = SAMPLE_BITS + SLOT_W;
	localparam int DIVCNT_W    = $clog2(SUM_W);
	localparam int CMP_W       = ((SUM_W > 12) ? SUM_W : 12) + 2;

	// Fixed field widths of the channels.
	localparam int OPC_W      = 3;
	localparam int SENSE_W    = 12;
	localparam int AVG_W      = 12;
	localparam int MARGIN_W   = 12;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Request opcodes.
	localparam logic [OPC_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OPC_W-1:0] OP_FORWARD = 3'd1;
	localparam logic [OPC_W-1:0] OP_BACK    = 3'd2;
	localparam logic [OPC_W-1:0] OP_STOP    = 3'd3;
	localparam logic [OPC_W-1:0] OP_REVERSE = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_MARGIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_JAM_DISABLE     = 2'd3;

	// Configuration reset values.
	localparam logic [MARGIN_W-1:0] RST_STALL_MARGIN    = 12'd100;
	localparam logic [TICK_W-1:0]   RST_SETTLE_TICKS    = 16'd1000;
	localparam logic [TICK_W-1:0]   RST_SAMPLE_INTERVAL = 16'd100;

	// Motor direction.
	typedef enum logic [1:0] {
		DIR_STOPPED  = 2'd0,
		DIR_FORWARD  = 2'd1,
		DIR_BACKWARD = 2'd2
	} dir_t;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_CHK  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic div_step;
		logic check;
		logic publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_div;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

// ===== src/msr_ifs.sv =====
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on msr_pkg for the field widths.
`default_nettype none

// Request channel: opcode and sense sample.
interface msr_cmd_if;
	import msr_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPC_W-1:0]    opcode;
	logic [SENSE_W-1:0]  sense_sample;
	modport source (output valid, output opcode, output sense_sample, input ready);
	modport sink (input valid, input opcode, input sense_sample, output ready);
endinterface

// Result channel: drive lines, stall flag and average.
interface msr_res_if;
	import msr_pkg::*;
	logic              valid;
	logic              ready;
	logic              drive_fwd;
	logic              drive_bwd;
	logic              stall_seen;
	logic [AVG_W-1:0]  sample_average;
	modport source (output valid, output drive_fwd, output drive_bwd,
		output stall_seen, output sample_average, input ready);
	modport sink (input valid, input drive_fwd, input drive_bwd,
		input stall_seen, input sample_average, output ready);
endinterface

// Configuration write channel.
interface msr_cfg_if;
	import msr_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   reg_index;
	logic [CFG_DATA_W-1:0]  wdata;
	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== src/motor_stall_reverser_core.sv =====
// Top level of the motor stall reverser: joins controller and datapath.
// Depends on msr_pkg, the channel interfaces, msr_ctrl and msr_dp.
// Commands, and ticks that compute no average, pass from acceptance through the
// execute and publish steps to the result register. Ticks that average the ring
// add SUM_W divider steps and a check step between execute and publish (SUM_W = 15
// at default sizing). One request is worked on at a time; an unread result holds
// the next request in its publish step. Reset is asynchronous, active low, and
// restores the register defaults, stops the motor and empties the sample ring.
`default_nettype none

module motor_stall_reverser_core (
	input  wire         clk,
	input  wire         arst_n,
	msr_cmd_if.sink     cmd_ch,
	msr_res_if.source   res_ch,
	msr_cfg_if.sink     cfg_ch
);
	import msr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Configuration writes are always taken.
	assign cfg_ch.ready = 1'b1;

	// Controller.
	msr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd_ch.valid),
		.req_ready (cmd_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath.
	msr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (cmd_ch.opcode),
		.sense_sample   (cmd_ch.sense_sample),
		.cfg_we         (cfg_ch.valid),
		.cfg_index      (cfg_ch.reg_index),
		.cfg_wdata      (cfg_ch.wdata),
		.res_valid      (res_ch.valid),
		.res_ready      (res_ch.ready),
		.res_drive_fwd  (res_ch.drive_fwd),
		.res_drive_bwd  (res_ch.drive_bwd),
		.res_stall_seen (res_ch.stall_seen),
		.res_average    (res_ch.sample_average)
	);

endmodule

`default_nettype wire

// ===== src/msr_ctrl.sv =====
// Controller state machine of the motor stall reverser.
// Depends on msr_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module msr_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  msr_pkg::sts_t     sts,
	output msr_pkg::cmd_t     cmd
);
	import msr_pkg::*;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.needs_div ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				cmd.check = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/msr_dp.sv =====
// Datapath of the motor stall reverser: configuration, motor state,
// sample ring, serial divider and result register. Depends on msr_pkg.
`default_nettype none
`include "assert_macros.svh"

module msr_dp (
	input  wire                             clk,
	input  wire                             arst_n,
	input  msr_pkg::cmd_t                   cmd,
	output msr_pkg::sts_t                   sts,
	input  wire [msr_pkg::OPC_W-1:0]        opcode,
	input  wire [msr_pkg::SENSE_W-1:0]      sense_sample,
	input  wire                             cfg_we,
	input  wire [msr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [msr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                            res_valid,
	input  wire                             res_ready,
	output logic                            res_drive_fwd,
	output logic                            res_drive_bwd,
	output logic                            res_stall_seen,
	output logic [msr_pkg::AVG_W-1:0]       res_average
);
	import msr_pkg::*;

	// Configuration registers.
	logic [MARGIN_W-1:0] margin_q;
	logic [TICK_W-1:0]   settle_q;
	logic [TICK_W-1:0]   interval_q;
	logic                jam_dis_q;

	// Motor and ring state.
	dir_t                   dir_q;
	logic [TICK_W-1:0]      tsc_q;
	logic [TICK_W-1:0]      tss_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [FILL_W-1:0]      fill_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] ring_q [RING_DEPTH];

	// Captured request.
	logic [OPC_W-1:0]       opc_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	// Divider and per-request result.
	logic [FILL_W-1:0]   divisor_q;
	logic [FILL_W-1:0]   rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [DIVCNT_W-1:0] cnt_q;
	logic                stall_q;
	logic [AVG_W-1:0]    avg_q;

	// Combinational values.
	logic [TICK_W-1:0]      tsc_inc;
	logic [TICK_W-1:0]      tss_inc;
	logic                   is_tick;
	logic                   check_en;
	logic                   store_en;
	logic                   full;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       sum_new;
	logic [FILL_W-1:0]      fill_new;
	logic [SLOT_W-1:0]      slot_next;
	dir_t                   cmd_dir;
	logic                   dir_change;
	logic [FILL_W:0]        rem_sh;
	logic [FILL_W:0]        rem_sub;
	logic                   stall_hit;

	// Tick bookkeeping and the store decision.
	always_comb begin
		tsc_inc    = (tsc_q == '1) ? tsc_q : tsc_q + 1'b1;
		tss_inc    = (tss_q == '1) ? tss_q : tss_q + 1'b1;
		is_tick    = (opc_q == OP_TICK);
		check_en   = is_tick && (dir_q == DIR_FORWARD) && !jam_dis_q && (tsc_inc >= settle_q);
		store_en   = check_en && (tss_inc >= interval_q);
		full       = (fill_q == FILL_W'(RING_DEPTH));
		old_sample = full ? ring_q[slot_q] : '0;
		sum_new    = store_en ? (sum_q - SUM_W'(old_sample) + SUM_W'(sample_q)) : sum_q;
		fill_new   = (store_en && !full) ? fill_q + 1'b1 : fill_q;
		slot_next  = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
	end

	// Direction requested by a command.
	always_comb begin
		cmd_dir = dir_q;
		unique case (opc_q)
			OP_FORWARD: cmd_dir = DIR_FORWARD;
			OP_BACK:    cmd_dir = DIR_BACKWARD;
			OP_STOP:    cmd_dir = DIR_STOPPED;
			OP_REVERSE: begin
				if (dir_q == DIR_FORWARD) begin
					cmd_dir = DIR_BACKWARD;
				end else if (dir_q == DIR_BACKWARD) begin
					cmd_dir = DIR_FORWARD;
				end
			end
			default: cmd_dir = dir_q;
		endcase
		dir_change = (cmd_dir != dir_q);
	end

	// One restoring division step and the stall comparison.
	always_comb begin
		rem_sh    = {rem_q, quo_q[SUM_W-1]};
		rem_sub   = rem_sh - {1'b0, divisor_q};
		stall_hit = CMP_W'(quo_q) > (CMP_W'(sample_q) + CMP_W'(margin_q));
	end

	// Status towards the controller.
	always_comb begin
		sts.needs_div = check_en && (fill_new != '0);
		sts.div_last  = (cnt_q == DIVCNT_W'(SUM_W - 1));
		sts.out_busy  = res_valid && !res_ready;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q   <= RST_STALL_MARGIN;
			settle_q   <= RST_SETTLE_TICKS;
			interval_q <= RST_SAMPLE_INTERVAL;
			jam_dis_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STALL_MARGIN:    margin_q   <= cfg_wdata[MARGIN_W-1:0];
				CFG_SETTLE_TICKS:    settle_q   <= cfg_wdata[TICK_W-1:0];
				CFG_SAMPLE_INTERVAL: interval_q <= cfg_wdata[TICK_W-1:0];
				CFG_JAM_DISABLE:     jam_dis_q  <= cfg_wdata[0];
				default:             jam_dis_q  <= jam_dis_q;
			endcase
		end
	end

	// Motor state, tick counters and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_STOPPED;
			tsc_q  <= '0;
			tss_q  <= '0;
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.exec) begin
			if (is_tick) begin
				tsc_q <= tsc_inc;
				tss_q <= store_en ? '0 : tss_inc;
				if (store_en) begin
					sum_q  <= sum_new;
					fill_q <= fill_new;
					slot_q <= slot_next;
				end
			end else if (dir_change) begin
				dir_q  <= cmd_dir;
				tsc_q  <= '0;
				slot_q <= '0;
				fill_q <= '0;
				sum_q  <= '0;
			end
		end else if (cmd.check && stall_hit) begin
			dir_q  <= DIR_BACKWARD;
			tsc_q  <= '0;
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end
	end

	// Ring storage; entries beyond the fill count are never read.
	always_ff @(posedge clk) begin
		if (cmd.exec && store_en) begin
			ring_q[slot_q] <= sample_q;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opc_q    <= opcode;
			sample_q <= SAMPLE_BITS'(sense_sample);
		end
	end

	// Serial divider and per-request result.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rem_q     <= '0;
			quo_q     <= sum_new;
			divisor_q <= fill_new;
			cnt_q     <= '0;
			stall_q   <= 1'b0;
			avg_q     <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, divisor_q}) begin
				rem_q <= rem_sub[FILL_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[FILL_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.check) begin
			stall_q <= stall_hit;
			avg_q   <= AVG_W'(quo_q);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.publish) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			res_drive_fwd  <= (dir_q == DIR_FORWARD);
			res_drive_bwd  <= (dir_q == DIR_BACKWARD);
			res_stall_seen <= stall_q;
			res_average    <= avg_q;
		end
	end

	// The fill count never passes the ring depth.
	`MSR_ASSERT(a_fill_bound, fill_q <= FILL_W'(RING_DEPTH), "fill count above ring depth")
	// Until the ring is full the write slot tracks the fill count.
	`MSR_ASSERT(a_slot_tracks_fill, (fill_q != FILL_W'(RING_DEPTH)) |-> (slot_q == SLOT_W'(fill_q)), "write slot out of step with fill count")
	// A detected stall reverses the motor and empties the ring.
	`MSR_ASSERT_NEXT(a_stall_reverses, cmd.check && stall_hit, (dir_q == DIR_BACKWARD) && (fill_q == '0) && (sum_q == '0), "stall did not reverse and clear")

endmodule

`default_nettype wire
